/* sv/tbmc_pkg.sv */
// ----------------------------------------------------------------------------
// tbmc_pkg
// Shared types and constants for the two-button long-press mode controller.
// ----------------------------------------------------------------------------
package tbmc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LONG_PRESS_LIMIT = 2'd0;
   localparam logic [1:0] CSR_BLINK_PERIOD     = 2'd1;
   localparam logic [1:0] CSR_FULL_BLINK_PHASE = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] LONG_PRESS_LIMIT_RST = 8'd20;
   localparam logic [4:0] BLINK_PERIOD_RST     = 5'd30;
   localparam logic [4:0] FULL_BLINK_PHASE_RST = 5'd15;

   // Saturation value of the press counter.
   localparam logic [7:0] PRESS_TICKS_MAX = 8'hFF;

   // System modes.
   localparam logic [1:0] MODE_RECORDING = 2'd0;
   localparam logic [1:0] MODE_INSTANT   = 2'd1;
   localparam logic [1:0] MODE_TRANSFER  = 2'd2;
   localparam logic [1:0] MODE_OTHER     = 2'd3;

   // Input item kinds and button identifiers.
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_BUTTON = 1'b1;
   localparam logic BTN_WAKE    = 1'b0;
   localparam logic BTN_SEND    = 1'b1;

   // Action codes.
   typedef enum logic [2:0] {
      ACT_NONE           = 3'd0,
      ACT_SHUTDOWN       = 3'd1,
      ACT_CLEAR_SHUTDOWN = 3'd2,
      ACT_ADVERTISE      = 3'd3,
      ACT_DISCONNECT     = 3'd4,
      ACT_TRANSFER       = 3'd5
   } action_type;

   // One input beat.
   typedef struct packed {
      logic       func;
      logic       which_button;
      logic       is_push;
      logic [1:0] mode_in;
      logic       storage_full;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [1:0] mode_out;
      action_type action;
      logic       adv_led;
      logic       conn_led;
   } rsp_type;

endpackage

/* sv/tbmc_in_stage.sv */
// ----------------------------------------------------------------------------
// tbmc_in_stage
// Input register: captures one request beat and holds it until processed.
// ----------------------------------------------------------------------------
module tbmc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tbmc_pkg::req_type req_item,
   input  logic             advance,
   output logic             item_valid,
   output tbmc_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   tbmc_pkg::req_type item_ff;
   logic              take;

   // The register frees up in the same cycle its beat moves on.
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* sv/tbmc_core.sv */
// ----------------------------------------------------------------------------
// tbmc_core
// Configuration registers, controller state and the per-beat update logic.
// ----------------------------------------------------------------------------
module tbmc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic              step,
   input  tbmc_pkg::req_type item,
   output tbmc_pkg::rsp_type result
);

   // Configuration registers.
   logic [7:0] limit_ff;
   logic [4:0] period_ff;
   logic [4:0] full_phase_ff;

   // Controller state.
   logic [4:0] phase_ff,  phase_in;
   logic [7:0] ticks_ff,  ticks_in;
   logic       wake_ff,   wake_in;
   logic       send_ff,   send_in;
   logic       adv_ff,    adv_in;
   logic       conn_ff,   conn_in;

   // Configuration writes; an unused index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= tbmc_pkg::LONG_PRESS_LIMIT_RST;
         period_ff     <= tbmc_pkg::BLINK_PERIOD_RST;
         full_phase_ff <= tbmc_pkg::FULL_BLINK_PHASE_RST;
      end else if (csr_we) begin
         case (csr_index)
            tbmc_pkg::CSR_LONG_PRESS_LIMIT: limit_ff      <= csr_wdata;
            tbmc_pkg::CSR_BLINK_PERIOD:     period_ff     <= csr_wdata[4:0];
            tbmc_pkg::CSR_FULL_BLINK_PHASE: full_phase_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Next state and result for the beat in the input register.
   always_comb begin
      logic [5:0]           phase_inc;
      logic [7:0]           ticks_sat;
      logic                 other_held;
      logic                 is_long;
      logic [1:0]           mode;
      tbmc_pkg::action_type act;

      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      wake_in    = wake_ff;
      send_in    = send_ff;
      adv_in     = adv_ff;
      conn_in    = conn_ff;
      mode       = item.mode_in;
      act        = tbmc_pkg::ACT_NONE;
      phase_inc  = {1'b0, phase_ff} + 6'd1;
      ticks_sat  = (ticks_ff == tbmc_pkg::PRESS_TICKS_MAX) ? ticks_ff : ticks_ff + 8'd1;
      other_held = (item.which_button == tbmc_pkg::BTN_WAKE) ? send_ff : wake_ff;
      is_long    = ticks_ff > limit_ff;

      if (item.func == tbmc_pkg::FUNC_TICK) begin
         // Blink pattern in recording mode.
         if (item.mode_in == tbmc_pkg::MODE_RECORDING) begin
            adv_in = (phase_ff == 5'd0);
            if (item.storage_full) begin
               conn_in = (phase_ff == full_phase_ff);
            end
         end
         // Phase wraps to zero on reaching the period.
         phase_in = (phase_inc >= {1'b0, period_ff}) ? 5'd0 : phase_inc[4:0];
         // Press timing lights both LEDs once the press turns long.
         if (wake_ff || send_ff) begin
            ticks_in = ticks_sat;
            if (ticks_sat > limit_ff) begin
               adv_in  = 1'b1;
               conn_in = 1'b1;
            end
         end
      end else if (!other_held) begin
         if (item.is_push) begin
            ticks_in = 8'd0;
            if (item.which_button == tbmc_pkg::BTN_WAKE) begin
               wake_in = 1'b1;
            end else begin
               send_in = 1'b1;
            end
         end else begin
            ticks_in = 8'd0;
            if (item.which_button == tbmc_pkg::BTN_WAKE) begin
               // Wakeup button release.
               wake_in = 1'b0;
               if (is_long) begin
                  act = tbmc_pkg::ACT_SHUTDOWN;
               end else if (item.mode_in == tbmc_pkg::MODE_RECORDING) begin
                  mode = tbmc_pkg::MODE_INSTANT;
                  act  = tbmc_pkg::ACT_ADVERTISE;
               end else if (item.mode_in == tbmc_pkg::MODE_INSTANT ||
                            item.mode_in == tbmc_pkg::MODE_TRANSFER) begin
                  mode = tbmc_pkg::MODE_RECORDING;
                  act  = tbmc_pkg::ACT_DISCONNECT;
               end
            end else begin
               // Send button release.
               send_in = 1'b0;
               if (is_long) begin
                  act = tbmc_pkg::ACT_CLEAR_SHUTDOWN;
               end else if (item.mode_in == tbmc_pkg::MODE_RECORDING) begin
                  mode    = tbmc_pkg::MODE_TRANSFER;
                  adv_in  = 1'b0;
                  conn_in = 1'b0;
                  act     = tbmc_pkg::ACT_TRANSFER;
               end else if (item.mode_in == tbmc_pkg::MODE_TRANSFER) begin
                  act = tbmc_pkg::ACT_DISCONNECT;
               end
            end
         end
      end

      result.mode_out = mode;
      result.action   = act;
      result.adv_led  = adv_in;
      result.conn_led = conn_in;
   end

   // State advances once per processed beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 5'd0;
         ticks_ff <= 8'd0;
         wake_ff  <= 1'b0;
         send_ff  <= 1'b0;
         adv_ff   <= 1'b0;
         conn_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         wake_ff  <= wake_in;
         send_ff  <= send_in;
         adv_ff   <= adv_in;
         conn_ff  <= conn_in;
      end
   end

endmodule

/* sv/tbmc_out_stage.sv */
// ----------------------------------------------------------------------------
// tbmc_out_stage
// Result register: holds one response beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tbmc_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  tbmc_pkg::rsp_type result,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tbmc_pkg::rsp_type rsp_item
);

   logic              valid_ff;
   logic              valid_in;
   tbmc_pkg::rsp_type item_ff;

   // Valid stays up until the beat is taken or replaced by a new one.
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

/* sv/two_button_long_press_mode_controller.sv */
// ----------------------------------------------------------------------------
// two_button_long_press_mode_controller
// Top level: input register, state update logic and result register.
// ----------------------------------------------------------------------------
// The controller takes one beat per clock cycle on the req_ channel while
// the consumer keeps rsp_ready high, and returns exactly one rsp_ beat for
// each, in order, after the input register and the result register. The
// rate is set by the state update that sits between those two registers;
// a stalled result holds in the result register while the input register
// still takes one more beat. Configuration writes on the csr_ port take
// effect at once and belong in idle periods.
module two_button_long_press_mode_controller (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic       req_which_button,
   input  logic       req_is_push,
   input  logic [1:0] req_mode_in,
   input  logic       req_storage_full,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_mode_out,
   output logic [2:0] rsp_action,
   output logic       rsp_adv_led,
   output logic       rsp_conn_led,
   // Configuration port.
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   tbmc_pkg::req_type req_item;
   tbmc_pkg::req_type item;
   tbmc_pkg::rsp_type result;
   tbmc_pkg::rsp_type rsp_item;
   logic              item_valid;
   logic              advance;

   // Gather the request fields.
   assign req_item.func         = req_func;
   assign req_item.which_button = req_which_button;
   assign req_item.is_push      = req_is_push;
   assign req_item.mode_in      = req_mode_in;
   assign req_item.storage_full = req_storage_full;

   // A beat moves on when the result register is empty or being emptied.
   assign advance = item_valid && (!rsp_valid || rsp_ready);

   tbmc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tbmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .item      (item),
      .result    (result)
   );

   tbmc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Spread the result fields onto their ports.
   assign rsp_mode_out = rsp_item.mode_out;
   assign rsp_action   = rsp_item.action;
   assign rsp_adv_led  = rsp_item.adv_led;
   assign rsp_conn_led = rsp_item.conn_led;

endmodule

/* sv/tbmc_checker.sv */
// ----------------------------------------------------------------------------
// tbmc_checker
// Port-level checks for the two-button long-press mode controller.
// ----------------------------------------------------------------------------
module tbmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_mode_out,
   input logic [2:0] rsp_action,
   input logic       rsp_adv_led,
   input logic       rsp_conn_led
);

   // No response beat is shown right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_out) &&
      $stable(rsp_action) && $stable(rsp_adv_led) && $stable(rsp_conn_led))
      else $error("stalled response changed");

   // Starting a transfer enters transfer mode with both LEDs dark.
   a_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == tbmc_pkg::ACT_TRANSFER |->
      rsp_mode_out == tbmc_pkg::MODE_TRANSFER && !rsp_adv_led && !rsp_conn_led)
      else $error("transfer action with wrong mode or LEDs");

   // Advertising always comes with instant report mode.
   a_advertise: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == tbmc_pkg::ACT_ADVERTISE |->
      rsp_mode_out == tbmc_pkg::MODE_INSTANT)
      else $error("advertise action with wrong mode");

   // A disconnect ends in recording or transfer mode.
   a_disconnect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == tbmc_pkg::ACT_DISCONNECT |->
      rsp_mode_out == tbmc_pkg::MODE_RECORDING ||
      rsp_mode_out == tbmc_pkg::MODE_TRANSFER)
      else $error("disconnect action with wrong mode");

endmodule

bind two_button_long_press_mode_controller tbmc_checker u_tbmc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_mode_out (rsp_mode_out),
   .rsp_action   (rsp_action),
   .rsp_adv_led  (rsp_adv_led),
   .rsp_conn_led (rsp_conn_led)
);
